/* rtl/mtbc_pkg.sv */
// Shared types, constants and cell-level functions of the Mantis cipher datapath.
package mtbc_pkg;

	// Four row words of sixteen bits; row 0 holds bytes 0 (low) and 1 (high).
	typedef logic [3:0][15:0] rows_t;

	// Control that travels with each word into a round stage.
	typedef struct packed {
		logic valid;
		logic active;
	} stage_ctl_t;

	// Configuration register indexes, taken from paddr[4:3].
	localparam logic [1:0] REG_K0     = 2'd0;
	localparam logic [1:0] REG_K1     = 2'd1;
	localparam logic [1:0] REG_K0P    = 2'd2;
	localparam logic [1:0] REG_ROUNDS = 2'd3;

	localparam logic [63:0] ALPHA = 64'h243F6A8885A308D3;

	localparam logic [63:0] ROUND_CONSTS [8] = '{
		64'h13198A2E03707344, 64'hA4093822299F31D0,
		64'h082EFA98EC4E6C89, 64'h452821E638D01377,
		64'hBE5466CF34E90C6C, 64'hC0AC29B7C97C50DD,
		64'h3F84D5B5B5470917, 64'h9216D5D98979FB1B
	};

	localparam logic [3:0] SBOX [16] = '{
		4'hC, 4'hA, 4'hD, 4'h3, 4'hE, 4'hB, 4'hF, 4'h7,
		4'h8, 4'h9, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6
	};

	// Split a 64-bit value into row words, most significant byte first.
	function automatic rows_t split_rows(input logic [63:0] x);
		rows_t r;
		for (int i = 0; i < 4; i++) begin
			r[i][7:0]  = x[63-16*i -: 8];
			r[i][15:8] = x[55-16*i -: 8];
		end
		return r;
	endfunction

	// Inverse of split_rows.
	function automatic logic [63:0] join_rows(input rows_t r);
		logic [63:0] x;
		for (int i = 0; i < 4; i++) begin
			x[63-16*i -: 8] = r[i][7:0];
			x[55-16*i -: 8] = r[i][15:8];
		end
		return x;
	endfunction

	// S-box on all sixteen cells.
	function automatic rows_t sub_cells(input rows_t s);
		rows_t r;
		for (int i = 0; i < 4; i++) begin
			for (int n = 0; n < 4; n++) begin
				r[i][4*n +: 4] = SBOX[s[i][4*n +: 4]];
			end
		end
		return r;
	endfunction

	// Column mix: each row becomes the xor of the other three.
	function automatic rows_t mix(input rows_t s);
		rows_t r;
		r[0] = s[1] ^ s[2] ^ s[3];
		r[1] = s[0] ^ s[2] ^ s[3];
		r[2] = s[0] ^ s[1] ^ s[3];
		r[3] = s[0] ^ s[1] ^ s[2];
		return r;
	endfunction

	// Tweak permutation h.
	function automatic rows_t tweak_fwd(input rows_t t);
		rows_t r;
		r[1] = t[0];
		r[3] = t[2];
		r[0] = {t[3][15:8], t[1][15:12], t[1][3:0]};
		r[2] = {t[3][3:0], t[1][7:4], t[1][11:8], t[3][7:4]};
		return r;
	endfunction

	// Inverse tweak permutation.
	function automatic rows_t tweak_inv(input rows_t t);
		rows_t r;
		r[0] = t[1];
		r[2] = t[3];
		r[1] = {t[0][7:4], t[2][7:4], t[2][11:8], t[0][3:0]};
		r[3] = {t[0][15:8], t[2][3:0], t[2][15:12]};
		return r;
	endfunction

	// Cell permutation P.
	function automatic rows_t perm_fwd(input rows_t s);
		rows_t r;
		r[0] = {s[1][15:12], s[3][3:0], s[0][7:4], s[2][11:8]};
		r[1] = {s[3][7:4], s[1][11:8], s[2][15:12], s[0][3:0]};
		r[2] = {s[0][11:8], s[2][7:4], s[1][3:0], s[3][15:12]};
		r[3] = {s[2][3:0], s[0][15:12], s[3][11:8], s[1][7:4]};
		return r;
	endfunction

	// Inverse cell permutation.
	function automatic rows_t perm_inv(input rows_t s);
		rows_t r;
		r[0] = {s[3][11:8], s[2][15:12], s[0][7:4], s[1][3:0]};
		r[1] = {s[0][15:12], s[1][11:8], s[3][3:0], s[2][7:4]};
		r[2] = {s[1][7:4], s[0][3:0], s[2][11:8], s[3][15:12]};
		r[3] = {s[2][3:0], s[3][7:4], s[1][15:12], s[0][11:8]};
		return r;
	endfunction

endpackage

/* rtl/mantis_tweakable_block_cipher_unit.sv */
// Top level of the pipelined Mantis tweakable block cipher.
//
// Usage: raise start with block_in and tweak_in for one cycle per word. busy
// is always low, so a new word is taken in every cycle. Each result appears
// on block_out for exactly one cycle with done high, in the order taken.
// The pipeline is one whitening stage, MAX_ROUNDS forward round stages,
// one middle stage, MAX_ROUNDS reverse round stages and one output
// whitening stage. Throughput is one word per cycle.
// The round count register selects how many of the round stages do work;
// the others pass the word through, so latency does not depend on it.
// Keys and the round count are set through the APB port: k0 at 0x00, k1 at
// 0x08, k0prime at 0x10 and the round count at 0x18 (values above
// MAX_ROUNDS act as MAX_ROUNDS). Write them only with no word in flight.
// Reset clears all valid bits and the keys and sets the round count to 7.
// The receiver cannot stall: done is a one-cycle strobe.
module mantis_tweakable_block_cipher_unit #(
	parameter int unsigned MAX_ROUNDS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] block_in,
	input  logic [63:0] tweak_in,
	output logic        done,
	output logic [63:0] block_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int unsigned CNT_W   = $clog2(MAX_ROUNDS + 1);
	localparam int unsigned LATENCY = 2 * MAX_ROUNDS + 3;

	logic [63:0] k0_q;
	logic [63:0] k1_q;
	logic [63:0] k0p_q;
	logic [3:0]  rounds_q;

	logic [CNT_W-1:0] rounds_eff;
	mtbc_pkg::rows_t  k1_rows;
	mtbc_pkg::rows_t  k1a_rows;

	logic                        wr_en;
	logic [MAX_ROUNDS:0]         fwd_valid;
	mtbc_pkg::rows_t             fwd_state [MAX_ROUNDS+1];
	mtbc_pkg::rows_t             fwd_tweak [MAX_ROUNDS+1];
	logic [MAX_ROUNDS:0]         rev_valid;
	mtbc_pkg::rows_t             rev_state [MAX_ROUNDS+1];
	mtbc_pkg::rows_t             rev_tweak [MAX_ROUNDS+1];

	logic            valid_s1;
	mtbc_pkg::rows_t state_s1;
	mtbc_pkg::rows_t tweak_s1;
	logic            done_s4;
	logic [63:0]     block_s4;

	// Configuration port: writes in the access phase, reads are combinational.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k0_q     <= '0;
			k1_q     <= '0;
			k0p_q    <= '0;
			rounds_q <= 4'd7;
		end else if (wr_en) begin
			case (paddr[4:3])
				mtbc_pkg::REG_K0:     k0_q     <= pwdata;
				mtbc_pkg::REG_K1:     k1_q     <= pwdata;
				mtbc_pkg::REG_K0P:    k0p_q    <= pwdata;
				mtbc_pkg::REG_ROUNDS: rounds_q <= pwdata[3:0];
				default:              k0_q     <= k0_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			mtbc_pkg::REG_K0:     prdata = k0_q;
			mtbc_pkg::REG_K1:     prdata = k1_q;
			mtbc_pkg::REG_K0P:    prdata = k0p_q;
			mtbc_pkg::REG_ROUNDS: prdata = {60'd0, rounds_q};
			default:              prdata = '0;
		endcase
	end

	// Effective round count, saturated at the number of round stages.
	always_comb begin
		if (rounds_q > 4'(MAX_ROUNDS)) begin
			rounds_eff = CNT_W'(MAX_ROUNDS);
		end else begin
			rounds_eff = CNT_W'(rounds_q);
		end
	end

	assign k1_rows  = mtbc_pkg::split_rows(k1_q);
	assign k1a_rows = k1_rows ^ mtbc_pkg::split_rows(mtbc_pkg::ALPHA);

	// The pipeline never holds a word back.
	assign busy = 1'b0;

	// Input whitening stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		state_s1 <= mtbc_pkg::split_rows(block_in ^ k0_q ^ k1_q ^ tweak_in);
		tweak_s1 <= mtbc_pkg::split_rows(tweak_in);
	end

	assign fwd_valid[0] = valid_s1;
	assign fwd_state[0] = state_s1;
	assign fwd_tweak[0] = tweak_s1;

	// Forward rounds; round i works only while i is below the round count.
	for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_fwd
		mtbc_pkg::stage_ctl_t ctl;
		assign ctl.valid  = fwd_valid[i];
		assign ctl.active = CNT_W'(i) < rounds_eff;

		mtbc_fwd_round #(.RC_IDX(i)) u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.state_in  (fwd_state[i]),
			.tweak_in  (fwd_tweak[i]),
			.round_key (k1_rows),
			.valid_out (fwd_valid[i+1]),
			.state_out (fwd_state[i+1]),
			.tweak_out (fwd_tweak[i+1])
		);
	end

	// Middle layer.
	mtbc_middle u_middle (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (fwd_valid[MAX_ROUNDS]),
		.state_in  (fwd_state[MAX_ROUNDS]),
		.tweak_in  (fwd_tweak[MAX_ROUNDS]),
		.valid_out (rev_valid[0]),
		.state_out (rev_state[0]),
		.tweak_out (rev_tweak[0])
	);

	// Reverse rounds, highest round first; inactive ones lead the chain.
	for (genvar j = 0; j < MAX_ROUNDS; j++) begin : g_rev
		mtbc_pkg::stage_ctl_t ctl;
		assign ctl.valid  = rev_valid[j];
		assign ctl.active = CNT_W'(MAX_ROUNDS - j) <= rounds_eff;

		mtbc_rev_round #(.RC_IDX(MAX_ROUNDS - 1 - j)) u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.state_in  (rev_state[j]),
			.tweak_in  (rev_tweak[j]),
			.round_key (k1a_rows),
			.valid_out (rev_valid[j+1]),
			.state_out (rev_state[j+1]),
			.tweak_out (rev_tweak[j+1])
		);
	end

	// Output whitening stage and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= rev_valid[MAX_ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		block_s4 <= mtbc_pkg::join_rows(rev_state[MAX_ROUNDS]
			^ mtbc_pkg::split_rows(k0p_q) ^ k1a_rows ^ rev_tweak[MAX_ROUNDS]);
	end

	assign done      = done_s4;
	assign block_out = block_s4;

	// A result only comes out of a word taken the full latency earlier.
	a_done_from_whitening: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(fwd_valid[0], LATENCY - 1))
		else $error("result strobe without a matching accepted word");

	// A word leaving the last reverse round always yields a result.
	a_rev_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		rev_valid[MAX_ROUNDS] |=> done)
		else $error("word lost between last round and output");

	// The middle stage sees exactly what left the last forward round.
	a_mid_follows_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		rev_valid[0] |-> $past(fwd_valid[MAX_ROUNDS]))
		else $error("middle stage valid without a forward word");

endmodule

/* rtl/mtbc_fwd_round.sv */
// One forward round stage of the Mantis pipeline, bypassed when inactive.
module mtbc_fwd_round #(
	parameter int unsigned RC_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mtbc_pkg::stage_ctl_t ctl,
	input  mtbc_pkg::rows_t     state_in,
	input  mtbc_pkg::rows_t     tweak_in,
	input  mtbc_pkg::rows_t     round_key,
	output logic                valid_out,
	output mtbc_pkg::rows_t     state_out,
	output mtbc_pkg::rows_t     tweak_out
);

	logic            valid_s1;
	mtbc_pkg::rows_t state_s1;
	mtbc_pkg::rows_t tweak_s1;
	mtbc_pkg::rows_t tweak_nxt;
	mtbc_pkg::rows_t state_nxt;

	// Round function: tweak update, S-box, key and constant add, permute, mix.
	always_comb begin
		tweak_nxt = mtbc_pkg::tweak_fwd(tweak_in);
		state_nxt = mtbc_pkg::sub_cells(state_in)
			^ mtbc_pkg::split_rows(mtbc_pkg::ROUND_CONSTS[RC_IDX])
			^ round_key ^ tweak_nxt;
		state_nxt = mtbc_pkg::mix(mtbc_pkg::perm_fwd(state_nxt));
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.valid;
		end
	end

	// Word registers; an inactive round passes the word through unchanged.
	always_ff @(posedge clk) begin
		if (ctl.active) begin
			state_s1 <= state_nxt;
			tweak_s1 <= tweak_nxt;
		end else begin
			state_s1 <= state_in;
			tweak_s1 <= tweak_in;
		end
	end

	assign valid_out = valid_s1;
	assign state_out = state_s1;
	assign tweak_out = tweak_s1;

endmodule

/* rtl/mtbc_middle.sv */
// Middle layer stage of the Mantis pipeline: S-box, mix, S-box.
module mtbc_middle (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_in,
	input  mtbc_pkg::rows_t state_in,
	input  mtbc_pkg::rows_t tweak_in,
	output logic            valid_out,
	output mtbc_pkg::rows_t state_out,
	output mtbc_pkg::rows_t tweak_out
);

	logic            valid_s1;
	mtbc_pkg::rows_t state_s1;
	mtbc_pkg::rows_t tweak_s1;

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	// The tweak rides along untouched.
	always_ff @(posedge clk) begin
		state_s1 <= mtbc_pkg::sub_cells(mtbc_pkg::mix(mtbc_pkg::sub_cells(state_in)));
		tweak_s1 <= tweak_in;
	end

	assign valid_out = valid_s1;
	assign state_out = state_s1;
	assign tweak_out = tweak_s1;

endmodule

/* rtl/mtbc_rev_round.sv */
// One reverse round stage of the Mantis pipeline, bypassed when inactive.
module mtbc_rev_round #(
	parameter int unsigned RC_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mtbc_pkg::stage_ctl_t ctl,
	input  mtbc_pkg::rows_t     state_in,
	input  mtbc_pkg::rows_t     tweak_in,
	input  mtbc_pkg::rows_t     round_key,
	output logic                valid_out,
	output mtbc_pkg::rows_t     state_out,
	output mtbc_pkg::rows_t     tweak_out
);

	logic            valid_s1;
	mtbc_pkg::rows_t state_s1;
	mtbc_pkg::rows_t tweak_s1;
	mtbc_pkg::rows_t state_nxt;

	// Inverse round: mix, inverse permute, key and constant add, S-box.
	always_comb begin
		state_nxt = mtbc_pkg::perm_inv(mtbc_pkg::mix(state_in))
			^ round_key ^ tweak_in
			^ mtbc_pkg::split_rows(mtbc_pkg::ROUND_CONSTS[RC_IDX]);
		state_nxt = mtbc_pkg::sub_cells(state_nxt);
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.valid;
		end
	end

	// Word registers; the tweak is stepped back after its use.
	always_ff @(posedge clk) begin
		if (ctl.active) begin
			state_s1 <= state_nxt;
			tweak_s1 <= mtbc_pkg::tweak_inv(tweak_in);
		end else begin
			state_s1 <= state_in;
			tweak_s1 <= tweak_in;
		end
	end

	assign valid_out = valid_s1;
	assign state_out = state_s1;
	assign tweak_out = tweak_s1;

endmodule
